/* rtl/trs_model_matrix_composer_defines.svh */
// Assertion macros for the model matrix composer checker
`ifndef TRS_MODEL_MATRIX_COMPOSER_DEFINES_SVH
`define TRS_MODEL_MATRIX_COMPOSER_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted
`define TRSMC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted
`define TRSMC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/trsmc_pkg.sv */
// Shared types, widths and helpers for the model matrix composer
`default_nettype none

package trsmc_pkg;

    typedef logic signed [31:0] fx_t;    // Q16.16
    typedef logic signed [15:0] quat_t;  // Q1.14

    localparam int NSTAGE = 5;
    localparam int NENT   = 9;   // rotation-scale entries
    localparam int NAXIS  = 3;

    localparam int PW    = 32;   // quaternion product, Q2.28
    localparam int RW    = 34;   // rotation entry, Q.28
    localparam int PLW   = 51;   // entry times low scale half
    localparam int PHW   = 50;   // entry times high scale half
    localparam int ACCW  = 66;   // full product
    localparam int FRAC  = 28;
    localparam int RNDW  = ACCW - FRAC;

    typedef logic signed [PW-1:0]  prod_t;
    typedef logic signed [RW-1:0]  rot_t;
    typedef logic signed [PLW-1:0] plo_t;
    typedef logic signed [PHW-1:0] phi_t;
    typedef logic signed [ACCW-1:0] acc_t;
    typedef logic signed [RNDW-1:0] rnd_t;

    localparam rot_t ONE_Q28  = rot_t'(34'sd268435456);
    localparam acc_t HALF_LSB = acc_t'(66'sd134217728);

    // product slots
    localparam int P_XX = 0;
    localparam int P_YY = 1;
    localparam int P_ZZ = 2;
    localparam int P_XY = 3;
    localparam int P_XZ = 4;
    localparam int P_YZ = 5;
    localparam int P_WX = 6;
    localparam int P_WY = 7;
    localparam int P_WZ = 8;

    function automatic rot_t ext_rot(input prod_t v);
        return {{(RW-PW){v[PW-1]}}, v};
    endfunction

    // clamp the rounded product to the Q16.16 range
    function automatic fx_t sat_fx(input rnd_t v);
        fx_t res;
        if (!v[RNDW-1] && (v[RNDW-2:31] != '0))
            res = 32'sh7FFF_FFFF;
        else if (v[RNDW-1] && (v[RNDW-2:31] != '1))
            res = 32'sh8000_0000;
        else
            res = v[31:0];
        return res;
    endfunction

endpackage

`default_nettype wire

/* rtl/trs_model_matrix_composer.sv */
// Model matrix composer: position, quaternion and scale to a 3x4 TRS matrix
//
// Usage: one object per transfer on the input channel (in_valid/in_ready)
// carrying position (Q16.16), unit quaternion (Q1.14) and per-axis scale
// (Q16.16). One transfer on the output channel (out_valid/out_ready) per
// object, in order: nine rotation-times-scale entries, rounded to nearest
// (ties away from zero) and saturated to Q16.16, plus the position as the
// translation column.
// Register stages, in order: quaternion products, rotation entries, split
// scale multiply, sum and round, saturate into the output register.
// Throughput: one object per cycle while out_ready is high; every stage
// advances independently.
// Stall: when out_ready is low the output register holds, and earlier
// stages keep filling until each holds an object; in_ready drops only once
// the whole pipeline is full. Nothing is dropped or repeated.
// Reset: asynchronous, clears all stage valid bits; the pipeline is empty
// and in_ready is high as soon as reset is released.
`default_nettype none

module trs_model_matrix_composer
    import trsmc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,

    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire fx_t   pos_x,
    input  wire fx_t   pos_y,
    input  wire fx_t   pos_z,
    input  wire quat_t quat_w,
    input  wire quat_t quat_x,
    input  wire quat_t quat_y,
    input  wire quat_t quat_z,
    input  wire fx_t   scale_x,
    input  wire fx_t   scale_y,
    input  wire fx_t   scale_z,

    output logic       out_valid,
    input  wire logic  out_ready,
    output fx_t        m00,
    output fx_t        m10,
    output fx_t        m20,
    output fx_t        m01,
    output fx_t        m11,
    output fx_t        m21,
    output fx_t        m02,
    output fx_t        m12,
    output fx_t        m22,
    output fx_t        tx,
    output fx_t        ty,
    output fx_t        tz
);

    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE-1:0] en;

    prod_t prod_reg [NENT];
    prod_t prod_next [NENT];
    rot_t  rot_reg  [NENT];
    rot_t  rot_next [NENT];
    plo_t  plo_reg  [NENT];
    plo_t  plo_next [NENT];
    phi_t  phi_reg  [NENT];
    phi_t  phi_next [NENT];
    rnd_t  rnd_reg  [NENT];
    rnd_t  rnd_next [NENT];
    fx_t   m_reg    [NENT];
    fx_t   m_next   [NENT];

    fx_t   sc1_reg  [NAXIS];
    fx_t   sc2_reg  [NAXIS];
    fx_t   pos_reg  [NSTAGE][NAXIS];

    // a stage loads when empty or when the stage after it moves on
    always_comb
    begin
        en[NSTAGE-1] = !vld_reg[NSTAGE-1] || out_ready;
        for (int k = NSTAGE - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NSTAGE-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NSTAGE; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // stage 1: quaternion products, Q2.28
    always_comb
    begin
        prod_next[P_XX] = quat_x * quat_x;
        prod_next[P_YY] = quat_y * quat_y;
        prod_next[P_ZZ] = quat_z * quat_z;
        prod_next[P_XY] = quat_x * quat_y;
        prod_next[P_XZ] = quat_x * quat_z;
        prod_next[P_YZ] = quat_y * quat_z;
        prod_next[P_WX] = quat_w * quat_x;
        prod_next[P_WY] = quat_w * quat_y;
        prod_next[P_WZ] = quat_w * quat_z;
    end

    // stage 2: rotation entries, column-major order m00 m10 m20 m01 ...
    always_comb
    begin
        rot_next[0] = ONE_Q28
                      - ((ext_rot(prod_reg[P_YY]) + ext_rot(prod_reg[P_ZZ])) <<< 1);
        rot_next[1] = (ext_rot(prod_reg[P_XY]) + ext_rot(prod_reg[P_WZ])) <<< 1;
        rot_next[2] = (ext_rot(prod_reg[P_XZ]) - ext_rot(prod_reg[P_WY])) <<< 1;
        rot_next[3] = (ext_rot(prod_reg[P_XY]) - ext_rot(prod_reg[P_WZ])) <<< 1;
        rot_next[4] = ONE_Q28
                      - ((ext_rot(prod_reg[P_XX]) + ext_rot(prod_reg[P_ZZ])) <<< 1);
        rot_next[5] = (ext_rot(prod_reg[P_YZ]) + ext_rot(prod_reg[P_WX])) <<< 1;
        rot_next[6] = (ext_rot(prod_reg[P_XZ]) + ext_rot(prod_reg[P_WY])) <<< 1;
        rot_next[7] = (ext_rot(prod_reg[P_YZ]) - ext_rot(prod_reg[P_WX])) <<< 1;
        rot_next[8] = ONE_Q28
                      - ((ext_rot(prod_reg[P_XX]) + ext_rot(prod_reg[P_YY])) <<< 1);
    end

    // stages 3 to 5 per entry: split multiply, sum and round, saturate
    for (genvar k = 0; k < NENT; k++)
    begin : g_ent
        localparam int Col = k / NAXIS;

        acc_t sum;
        acc_t biased;

        // scale split into a signed high half and an unsigned low half
        assign plo_next[k] = rot_reg[k] * $signed({1'b0, sc2_reg[Col][15:0]});
        assign phi_next[k] = rot_reg[k] * $signed(sc2_reg[Col][31:16]);

        assign sum = (acc_t'(phi_reg[k]) <<< 16) + acc_t'(plo_reg[k]);
        // half-LSB bias, less one for negatives, gives ties away from zero
        assign biased = sum + HALF_LSB - acc_t'({1'b0, sum[ACCW-1]});
        assign rnd_next[k] = biased[ACCW-1:FRAC];

        assign m_next[k] = sat_fx(rnd_reg[k]);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            prod_reg   <= prod_next;
            sc1_reg[0] <= scale_x;
            sc1_reg[1] <= scale_y;
            sc1_reg[2] <= scale_z;
            pos_reg[0][0] <= pos_x;
            pos_reg[0][1] <= pos_y;
            pos_reg[0][2] <= pos_z;
        end
        if (en[1])
        begin
            rot_reg    <= rot_next;
            sc2_reg    <= sc1_reg;
            pos_reg[1] <= pos_reg[0];
        end
        if (en[2])
        begin
            plo_reg    <= plo_next;
            phi_reg    <= phi_next;
            pos_reg[2] <= pos_reg[1];
        end
        if (en[3])
        begin
            rnd_reg    <= rnd_next;
            pos_reg[3] <= pos_reg[2];
        end
        if (en[4])
        begin
            m_reg      <= m_next;
            pos_reg[4] <= pos_reg[3];
        end
    end

    assign m00 = m_reg[0];
    assign m10 = m_reg[1];
    assign m20 = m_reg[2];
    assign m01 = m_reg[3];
    assign m11 = m_reg[4];
    assign m21 = m_reg[5];
    assign m02 = m_reg[6];
    assign m12 = m_reg[7];
    assign m22 = m_reg[8];
    assign tx  = pos_reg[NSTAGE-1][0];
    assign ty  = pos_reg[NSTAGE-1][1];
    assign tz  = pos_reg[NSTAGE-1][2];

endmodule

`default_nettype wire

/* rtl/trsmc_checker.sv */
// Port-level checks for the model matrix composer, bound to the top level
`default_nettype none

`include "trs_model_matrix_composer_defines.svh"

module trsmc_checker
    import trsmc_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire fx_t  pos_x,
    input wire fx_t  m00,
    input wire fx_t  tx
);

    // a stalled result must hold
    `TRSMC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(m00) && $stable(tx), "output changed while stalled")

    // a free output stage frees the whole pipeline
    `TRSMC_ASSERT_IMP(a_ready_free, clk, rst_n, out_ready || !out_valid, in_ready, "in_ready low with a free output stage")

    // with no stall, a transfer shows up at the output with its position as translation
    `TRSMC_ASSERT_NXT(a_latency, clk, rst_n, (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready, out_valid && (tx == $past(pos_x, 5)), "result missing or wrong translation after pipeline latency")

endmodule

bind trs_model_matrix_composer trsmc_checker u_trsmc_checker (.*);

`default_nettype wire
